@@ hw/rtl/kmp_stream_matcher_core_assert.svh @@
// Assertion macros for the KMP stream matcher core.
// Depends on nothing; included by the matcher core, which checks its own logic.
`ifndef KMP_STREAM_MATCHER_CORE_ASSERT_SVH
`define KMP_STREAM_MATCHER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define KMP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high
`define KMP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/kmp_pkg.sv @@
// Shared types and constants for the KMP stream matcher.
// No dependencies; used by the matcher core.
package kmp_pkg;

   localparam int unsigned MAX_PATTERN_DEFAULT = 256;
   localparam int unsigned KIND_WIDTH          = 2;
   localparam int unsigned SYM_WIDTH           = 8;
   localparam int unsigned POS_WIDTH           = 32;

   // Transaction kinds on the request channel
   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_APPEND  = 2'd0,
      KIND_TEXT    = 2'd1,
      KIND_CLEAR   = 2'd2,
      KIND_RESTART = 2'd3
   } kind_type;

   // Sequencer states, one-hot
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

endpackage

@@ hw/rtl/kmp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; instanced by the matcher core for the pattern and failure stores.
module kmp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the entry and register the read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/kmp_stream_matcher_core.sv @@
// Streaming Knuth-Morris-Pratt matcher: pattern store, failure table and walk sequencer.
// Depends on kmp_pkg, kmp_ram and kmp_stream_matcher_core_assert.svh.
//
// Usage: a transaction is taken when start is high and busy is low; each one gives
// exactly one result, shown for one cycle with rsp_strobe high, which cannot be held
// off. Clear, restart, a dropped pattern byte (store full), the first pattern byte and
// a text byte against an empty pattern give their result without a walk. Any other
// pattern or text byte enters the walk and takes k failure-link steps: each step
// is one read of the pattern and failure RAMs, which have registered read data.
// Over a stream k averages at most one. The pattern
// and failure RAMs need no clearing pass; the block is ready straight after reset.
`include "kmp_stream_matcher_core_assert.svh"

module kmp_stream_matcher_core #(
   parameter int unsigned MAX_PATTERN = kmp_pkg::MAX_PATTERN_DEFAULT,
   localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1),
   localparam int unsigned PAT_AW = $clog2(MAX_PATTERN)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [kmp_pkg::KIND_WIDTH-1:0] req_kind,
   input  logic [kmp_pkg::SYM_WIDTH-1:0]  req_symbol,
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [kmp_pkg::POS_WIDTH-1:0]  rsp_start_pos,
   output logic [LEN_W-1:0]               rsp_border_len,
   output logic                           rsp_overflow
);

   localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN);

   kmp_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0]              j_ff, j_in;
   logic [LEN_W-1:0]              limit_ff, limit_in;
   logic [kmp_pkg::SYM_WIDTH-1:0] sym_ff, sym_in;
   logic                          is_text_ff, is_text_in;
   logic [LEN_W-1:0]              pat_len_ff, pat_len_in;
   logic [LEN_W-1:0]              border_ff, border_in;
   logic [LEN_W-1:0]              match_len_ff, match_len_in;
   logic [kmp_pkg::POS_WIDTH-1:0] text_pos_ff, text_pos_in;

   logic                          rsp_strobe_ff, rsp_strobe_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [kmp_pkg::POS_WIDTH-1:0] rsp_start_pos_ff, rsp_start_pos_in;
   logic [LEN_W-1:0]              rsp_border_ff, rsp_border_in;
   logic                          rsp_overflow_ff, rsp_overflow_in;

   // RAM ports
   logic                          pat_we;
   logic [kmp_pkg::SYM_WIDTH-1:0] pat_rdata;
   logic                          fail_we;
   logic [LEN_W-1:0]              fail_waddr;
   logic [LEN_W-1:0]              fail_wdata;
   logic [LEN_W-1:0]              fail_rdata;
   logic [LEN_W-1:0]              rd_addr;

   // Walk decision on the entry just read
   logic             walk_sym_eq;
   logic             walk_cont;
   logic [LEN_W-1:0] walk_j;
   logic [LEN_W-1:0] text_j0;

   kmp_ram #(
      .WIDTH (kmp_pkg::SYM_WIDTH),
      .DEPTH (MAX_PATTERN)
   ) u_pattern_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (pat_len_ff[PAT_AW-1:0]),
      .wr_data (req_symbol),
      .rd_addr (rd_addr[PAT_AW-1:0]),
      .rd_data (pat_rdata)
   );

   kmp_ram #(
      .WIDTH (LEN_W),
      .DEPTH (MAX_PATTERN + 1)
   ) u_failure_ram (
      .clock   (clock),
      .wr_en   (fail_we),
      .wr_addr (fail_waddr),
      .wr_data (fail_wdata),
      .rd_addr (rd_addr),
      .rd_data (fail_rdata)
   );

   assign walk_sym_eq = (sym_ff == pat_rdata);
   assign walk_cont   = (j_ff != '0) && ((j_ff == limit_ff) || !walk_sym_eq);
   assign walk_j      = ((j_ff < limit_ff) && walk_sym_eq) ? j_ff + LEN_ONE : j_ff;
   assign text_j0     = (match_len_ff > pat_len_ff) ? '0 : match_len_ff;

   // Sequencer: take a transaction, walk the failure links, issue the result
   always_comb begin
      state_in         = state_ff;
      j_in             = j_ff;
      limit_in         = limit_ff;
      sym_in           = sym_ff;
      is_text_in       = is_text_ff;
      pat_len_in       = pat_len_ff;
      border_in        = border_ff;
      match_len_in     = match_len_ff;
      text_pos_in      = text_pos_ff;
      rsp_strobe_in    = 1'b0;
      rsp_found_in     = 1'b0;
      rsp_start_pos_in = '0;
      rsp_border_in    = '0;
      rsp_overflow_in  = 1'b0;
      pat_we           = 1'b0;
      fail_we          = 1'b0;
      fail_waddr       = limit_ff;
      fail_wdata       = walk_j;
      rd_addr          = j_ff;

      case (state_ff)
         kmp_pkg::ST_IDLE: begin
            if (start) begin
               sym_in = req_symbol;
               case (kmp_pkg::kind_type'(req_kind))
                  kmp_pkg::KIND_APPEND: begin
                     if (pat_len_ff >= LEN_MAX) begin
                        // Drop the byte and flag it
                        rsp_strobe_in   = 1'b1;
                        rsp_overflow_in = 1'b1;
                     end else if (pat_len_ff == '0) begin
                        // First byte: its failure value is zero
                        pat_we        = 1'b1;
                        fail_we       = 1'b1;
                        fail_waddr    = LEN_ONE;
                        fail_wdata    = '0;
                        pat_len_in    = LEN_ONE;
                        border_in     = '0;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        pat_we     = 1'b1;
                        is_text_in = 1'b0;
                        limit_in   = pat_len_ff + LEN_ONE;
                        j_in       = border_ff;
                        rd_addr    = border_ff;
                        state_in   = kmp_pkg::ST_WALK;
                     end
                  end
                  kmp_pkg::KIND_TEXT: begin
                     if (text_pos_ff != '1) begin
                        text_pos_in = text_pos_ff + kmp_pkg::POS_WIDTH'(1);
                     end
                     if (pat_len_ff == '0) begin
                        match_len_in  = '0;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        is_text_in = 1'b1;
                        limit_in   = pat_len_ff;
                        j_in       = text_j0;
                        rd_addr    = text_j0;
                        state_in   = kmp_pkg::ST_WALK;
                     end
                  end
                  kmp_pkg::KIND_CLEAR: begin
                     pat_len_in    = '0;
                     border_in     = '0;
                     match_len_in  = '0;
                     text_pos_in   = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  kmp_pkg::KIND_RESTART: begin
                     match_len_in  = '0;
                     text_pos_in   = '0;
                     rsp_strobe_in = 1'b1;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         kmp_pkg::ST_WALK: begin
            if (walk_cont) begin
               // Follow the failure link
               j_in    = fail_rdata;
               rd_addr = fail_rdata;
            end else begin
               state_in      = kmp_pkg::ST_IDLE;
               rsp_strobe_in = 1'b1;
               rsp_border_in = walk_j;
               if (is_text_ff) begin
                  if (walk_j == limit_ff) begin
                     // Full occurrence: report and fall back to the pattern's border
                     rsp_found_in     = 1'b1;
                     rsp_start_pos_in = text_pos_ff
                                        - kmp_pkg::POS_WIDTH'(limit_ff)
                                        + kmp_pkg::POS_WIDTH'(1);
                     match_len_in     = border_ff;
                  end else begin
                     match_len_in = walk_j;
                  end
               end else begin
                  // Record the new failure entry and grow the pattern
                  fail_we    = 1'b1;
                  border_in  = walk_j;
                  pat_len_in = limit_ff;
               end
            end
         end
         default: begin
            state_in = kmp_pkg::ST_IDLE;
         end
      endcase
   end

   // Hold control state under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kmp_pkg::ST_IDLE;
         pat_len_ff    <= '0;
         border_ff     <= '0;
         match_len_ff  <= '0;
         text_pos_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pat_len_ff    <= pat_len_in;
         border_ff     <= border_in;
         match_len_ff  <= match_len_in;
         text_pos_ff   <= text_pos_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Advance the walk and result payload
   always_ff @(posedge clock) begin
      j_ff             <= j_in;
      limit_ff         <= limit_in;
      sym_ff           <= sym_in;
      is_text_ff       <= is_text_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_start_pos_ff <= rsp_start_pos_in;
      rsp_border_ff    <= rsp_border_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

   assign busy           = (state_ff == kmp_pkg::ST_WALK);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_start_pos  = rsp_start_pos_ff;
   assign rsp_border_len = rsp_border_ff;
   assign rsp_overflow   = rsp_overflow_ff;

   // No result is shown while a walk is in progress
   `KMP_ASSERT_NOW(a_strobe_not_busy, clock, reset, rsp_strobe_ff, !busy, "result during walk")
   // The match state never exceeds the pattern
   `KMP_ASSERT_NOW(a_match_in_range, clock, reset, 1'b1, match_len_ff <= pat_len_ff, "match length beyond pattern")
   // The build border is a proper border of the pattern
   `KMP_ASSERT_NOW(a_border_proper, clock, reset, pat_len_ff != '0, border_ff < pat_len_ff, "border not proper")
   // The walk index stays within the current limit
   `KMP_ASSERT_NOW(a_walk_in_range, clock, reset, state_ff == kmp_pkg::ST_WALK, j_ff <= limit_ff, "walk index out of range")
   // A hit reports the whole pattern length
   `KMP_ASSERT_NOW(a_hit_length, clock, reset, rsp_strobe_ff && rsp_found_ff, rsp_border_ff == pat_len_ff, "hit length mismatch")

endmodule
